>>> hdl/xcfp_pkg.sv
package xcfp_pkg;

  localparam int unsigned BYTE_W = 8;
  localparam int unsigned LEN_W  = 7;
  localparam int unsigned STAT_W = 2;
  localparam int unsigned STEP_W = 4;

  typedef logic [STEP_W-1:0] step_t;

  localparam step_t STEP_HUNT   = 4'd0;
  localparam step_t STEP_SENDER = 4'd1;
  localparam step_t STEP_DEST   = 4'd2;
  localparam step_t STEP_LEN    = 4'd3;
  localparam step_t STEP_DATA   = 4'd4;
  localparam step_t STEP_CHECK  = 4'd5;
  localparam step_t STEP_END    = 4'd6;
  localparam step_t STEP_RD     = 4'd7;
  localparam step_t STEP_OUT    = 4'd8;

  localparam logic [STAT_W-1:0] ST_GOOD    = 2'd0;
  localparam logic [STAT_W-1:0] ST_BAD_END = 2'd1;
  localparam logic [STAT_W-1:0] ST_TOO_BIG = 2'd2;
  localparam logic [STAT_W-1:0] ST_BAD_SUM = 2'd3;

  localparam logic [1:0] REG_START_MARKER = 2'd0;
  localparam logic [1:0] REG_END_MARKER   = 2'd1;
  localparam logic [1:0] REG_MAX_LENGTH   = 2'd2;

  localparam logic [BYTE_W-1:0] RST_START_MARKER = 8'd2;
  localparam logic [BYTE_W-1:0] RST_END_MARKER   = 8'd3;
  localparam logic [LEN_W-1:0]  RST_MAX_LENGTH   = 7'd35;

  typedef enum logic [2:0] {
    COND_NEVER,
    COND_ALWAYS,
    COND_START,
    COND_TOO_BIG,
    COND_LEN_ZERO,
    COND_DATA_DONE,
    COND_END_ONE,
    COND_LAST
  } cond_t;

  typedef enum logic [1:0] {
    EMIT_NONE,
    EMIT_TOO_BIG,
    EMIT_END,
    EMIT_PAYLOAD
  } emit_t;

  typedef struct packed {
    logic  take_in;
    logic  wait_out;
    logic  clr_xor;
    logic  clr_cnt;
    logic  xor_en;
    logic  cnt_inc;
    logic  ld_sender;
    logic  ld_dest;
    logic  ld_len;
    logic  ld_check;
    logic  mem_wr;
    logic  mem_rd;
    emit_t emit;
    cond_t cond_a;
    step_t jmp_a;
    cond_t cond_b;
    step_t jmp_b;
  } cw_t;

  typedef struct packed {
    logic go;
    logic start_hit;
    logic too_big;
    logic len_zero;
    logic data_done;
    logic end_one;
    logic last_rd;
  } flags_t;

  typedef struct packed {
    logic [BYTE_W-1:0] start_marker;
    logic [BYTE_W-1:0] end_marker;
    logic [LEN_W-1:0]  max_length;
  } cfg_t;

  function automatic cw_t ucode(step_t s);
    cw_t w;
    w = '0;
    w.emit   = EMIT_NONE;
    w.cond_a = COND_NEVER;
    w.cond_b = COND_NEVER;
    w.jmp_a  = STEP_HUNT;
    w.jmp_b  = STEP_HUNT;
    unique case (s)
      STEP_HUNT: begin
        w.take_in = 1'b1;
        w.clr_xor = 1'b1;
        w.clr_cnt = 1'b1;
        w.cond_a  = COND_START;
        w.jmp_a   = STEP_SENDER;
        w.cond_b  = COND_ALWAYS;
        w.jmp_b   = STEP_HUNT;
      end
      STEP_SENDER: begin
        w.take_in   = 1'b1;
        w.ld_sender = 1'b1;
        w.xor_en    = 1'b1;
      end
      STEP_DEST: begin
        w.take_in = 1'b1;
        w.ld_dest = 1'b1;
        w.xor_en  = 1'b1;
      end
      STEP_LEN: begin
        w.take_in = 1'b1;
        w.ld_len  = 1'b1;
        w.xor_en  = 1'b1;
        w.clr_cnt = 1'b1;
        w.emit    = EMIT_TOO_BIG;
        w.cond_a  = COND_TOO_BIG;
        w.jmp_a   = STEP_HUNT;
        w.cond_b  = COND_LEN_ZERO;
        w.jmp_b   = STEP_CHECK;
      end
      STEP_DATA: begin
        w.take_in = 1'b1;
        w.mem_wr  = 1'b1;
        w.xor_en  = 1'b1;
        w.cnt_inc = 1'b1;
        w.cond_a  = COND_DATA_DONE;
        w.jmp_a   = STEP_CHECK;
        w.cond_b  = COND_ALWAYS;
        w.jmp_b   = STEP_DATA;
      end
      STEP_CHECK: begin
        w.take_in  = 1'b1;
        w.ld_check = 1'b1;
      end
      STEP_END: begin
        w.take_in = 1'b1;
        w.clr_cnt = 1'b1;
        w.emit    = EMIT_END;
        w.cond_a  = COND_END_ONE;
        w.jmp_a   = STEP_HUNT;
      end
      STEP_RD: begin
        w.mem_rd = 1'b1;
      end
      STEP_OUT: begin
        w.wait_out = 1'b1;
        w.cnt_inc  = 1'b1;
        w.emit     = EMIT_PAYLOAD;
        w.cond_a   = COND_LAST;
        w.jmp_a    = STEP_HUNT;
        w.cond_b   = COND_ALWAYS;
        w.jmp_b    = STEP_RD;
      end
      default: begin
        w.cond_a = COND_ALWAYS;
        w.jmp_a  = STEP_HUNT;
      end
    endcase
    return w;
  endfunction

endpackage

>>> hdl/xcfp_useq.sv
module xcfp_useq (
  input  logic             clk,
  input  logic             rst_n,
  input  xcfp_pkg::flags_t flags,
  output xcfp_pkg::cw_t    cw
);

  xcfp_pkg::step_t step_r;
  xcfp_pkg::step_t step_nxt;

  function automatic logic cond_hit(xcfp_pkg::cond_t c, xcfp_pkg::flags_t f);
    logic hit;
    unique case (c)
      xcfp_pkg::COND_NEVER:     hit = 1'b0;
      xcfp_pkg::COND_ALWAYS:    hit = 1'b1;
      xcfp_pkg::COND_START:     hit = f.start_hit;
      xcfp_pkg::COND_TOO_BIG:   hit = f.too_big;
      xcfp_pkg::COND_LEN_ZERO:  hit = f.len_zero;
      xcfp_pkg::COND_DATA_DONE: hit = f.data_done;
      xcfp_pkg::COND_END_ONE:   hit = f.end_one;
      xcfp_pkg::COND_LAST:      hit = f.last_rd;
      default:                  hit = 1'b0;
    endcase
    return hit;
  endfunction

  assign cw = xcfp_pkg::ucode(step_r);

  always_comb begin
    step_nxt = step_r;
    if (flags.go) begin
      priority if (cond_hit(cw.cond_a, flags)) begin
        step_nxt = cw.jmp_a;
      end else if (cond_hit(cw.cond_b, flags)) begin
        step_nxt = cw.jmp_b;
      end else begin
        step_nxt = xcfp_pkg::STEP_W'(step_r + 1'b1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= xcfp_pkg::STEP_HUNT;
    end else begin
      step_r <= step_nxt;
    end
  end

endmodule

>>> hdl/xcfp_dpath.sv
module xcfp_dpath #(
  parameter int unsigned PAYLOAD_DEPTH = 64
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  xcfp_pkg::cfg_t                  cfg,
  input  xcfp_pkg::cw_t                   cw,
  output xcfp_pkg::flags_t                flags,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [xcfp_pkg::BYTE_W-1:0]     rx_byte,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [xcfp_pkg::BYTE_W-1:0]     payload_byte,
  output logic [xcfp_pkg::BYTE_W-1:0]     sender,
  output logic [xcfp_pkg::BYTE_W-1:0]     destination,
  output logic [xcfp_pkg::STAT_W-1:0]     status,
  output logic                            has_payload,
  output logic                            last
);

  localparam int unsigned AW = (PAYLOAD_DEPTH > 1) ? $clog2(PAYLOAD_DEPTH) : 1;
  localparam logic [xcfp_pkg::LEN_W-1:0] DEPTH_L = xcfp_pkg::LEN_W'(PAYLOAD_DEPTH);

  logic [xcfp_pkg::BYTE_W-1:0] mem [0:PAYLOAD_DEPTH-1];
  logic [xcfp_pkg::BYTE_W-1:0] rd_q_r;

  logic [xcfp_pkg::BYTE_W-1:0] sender_r, dest_r, xor_r, check_r;
  logic [xcfp_pkg::LEN_W-1:0]  len_r, cnt_r;
  logic [xcfp_pkg::LEN_W-1:0]  cnt_inc;
  logic [xcfp_pkg::LEN_W-1:0]  limit;
  logic [AW-1:0]               addr;

  logic                        out_valid_r;
  logic [xcfp_pkg::BYTE_W-1:0] out_payload_r, out_sender_r, out_dest_r;
  logic [xcfp_pkg::STAT_W-1:0] out_status_r;
  logic                        out_has_r, out_last_r;

  logic out_free, end_bad, sum_bad, emit_now;
  logic [xcfp_pkg::STAT_W-1:0] emit_status;

  assign out_free  = !out_valid_r || out_tready;
  assign in_tready = cw.take_in && out_free;
  assign cnt_inc   = xcfp_pkg::LEN_W'(cnt_r + 1'b1);
  assign limit     = (cfg.max_length > DEPTH_L) ? DEPTH_L : cfg.max_length;
  assign addr      = cnt_r[AW-1:0];
  assign end_bad   = rx_byte != cfg.end_marker;
  assign sum_bad   = check_r != xor_r;

  always_comb begin
    flags.go        = cw.take_in ? (in_tvalid && in_tready) :
                      (cw.wait_out ? out_free : 1'b1);
    flags.start_hit = rx_byte == cfg.start_marker;
    flags.too_big   = rx_byte > {1'b0, limit};
    flags.len_zero  = rx_byte == '0;
    flags.data_done = cnt_inc >= len_r;
    flags.end_one   = end_bad || sum_bad || (len_r == '0);
    flags.last_rd   = cnt_inc == len_r;
  end

  always_comb begin
    unique case (cw.emit)
      xcfp_pkg::EMIT_NONE:    emit_now = 1'b0;
      xcfp_pkg::EMIT_TOO_BIG: emit_now = flags.too_big;
      xcfp_pkg::EMIT_END:     emit_now = flags.end_one;
      xcfp_pkg::EMIT_PAYLOAD: emit_now = 1'b1;
      default:                emit_now = 1'b0;
    endcase
    priority if (cw.emit == xcfp_pkg::EMIT_TOO_BIG) begin
      emit_status = xcfp_pkg::ST_TOO_BIG;
    end else if (cw.emit == xcfp_pkg::EMIT_END && end_bad) begin
      emit_status = xcfp_pkg::ST_BAD_END;
    end else if (cw.emit == xcfp_pkg::EMIT_END && sum_bad) begin
      emit_status = xcfp_pkg::ST_BAD_SUM;
    end else begin
      emit_status = xcfp_pkg::ST_GOOD;
    end
  end

  always_ff @(posedge clk) begin
    if (flags.go && cw.mem_wr && (cnt_r < DEPTH_L)) begin
      mem[addr] <= rx_byte;
    end
    if (flags.go && cw.mem_rd) begin
      rd_q_r <= mem[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sender_r <= '0;
      dest_r   <= '0;
      xor_r    <= '0;
      check_r  <= '0;
      len_r    <= '0;
      cnt_r    <= '0;
    end else if (flags.go) begin
      if (cw.ld_sender) sender_r <= rx_byte;
      if (cw.ld_dest)   dest_r   <= rx_byte;
      if (cw.ld_len)    len_r    <= rx_byte[xcfp_pkg::LEN_W-1:0];
      if (cw.ld_check)  check_r  <= rx_byte;
      if (cw.clr_xor) begin
        xor_r <= '0;
      end else if (cw.xor_en) begin
        xor_r <= xor_r ^ rx_byte;
      end
      if (cw.clr_cnt) begin
        cnt_r <= '0;
      end else if (cw.cnt_inc) begin
        cnt_r <= cnt_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (flags.go && emit_now) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (flags.go && emit_now) begin
      out_payload_r <= (cw.emit == xcfp_pkg::EMIT_PAYLOAD) ? rd_q_r : '0;
      out_sender_r  <= sender_r;
      out_dest_r    <= dest_r;
      out_status_r  <= emit_status;
      out_has_r     <= cw.emit == xcfp_pkg::EMIT_PAYLOAD;
      out_last_r    <= (cw.emit == xcfp_pkg::EMIT_PAYLOAD) ? flags.last_rd : 1'b1;
    end
  end

  assign out_tvalid   = out_valid_r;
  assign payload_byte = out_payload_r;
  assign sender       = out_sender_r;
  assign destination  = out_dest_r;
  assign status       = out_status_r;
  assign has_payload  = out_has_r;
  assign last         = out_last_r;

endmodule

>>> hdl/xor_checksum_frame_parser_unit.sv
// Timing: a single result item is offered in the cycle after its length or end byte is
// taken; a good frame's first payload item follows its end byte and a memory read step.
// Throughput: one received byte per cycle while the output register is free; payload
// then plays out as alternating memory read and output load steps, input held.
// Reset: synchronous, active low; loads configuration defaults and clears sequencer and
// counters, leaving the payload memory as it is.
module xor_checksum_frame_parser_unit #(
  parameter int unsigned PAYLOAD_DEPTH = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] rx_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [7:0] payload_byte, [15:8] sender, [23:16] destination
  output logic [2:0]  out_tuser,  // [1:0] status, [2] has_payload
  output logic        out_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data
);

  xcfp_pkg::cfg_t   cfg_r;
  xcfp_pkg::cw_t    cw;
  xcfp_pkg::flags_t flags;

  logic [7:0] payload_byte, sender, destination;
  logic [1:0] status;
  logic       has_payload, last;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.start_marker <= xcfp_pkg::RST_START_MARKER;
      cfg_r.end_marker   <= xcfp_pkg::RST_END_MARKER;
      cfg_r.max_length   <= xcfp_pkg::RST_MAX_LENGTH;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        xcfp_pkg::REG_START_MARKER: cfg_r.start_marker <= cfg_data;
        xcfp_pkg::REG_END_MARKER:   cfg_r.end_marker   <= cfg_data;
        xcfp_pkg::REG_MAX_LENGTH:   cfg_r.max_length   <= cfg_data[xcfp_pkg::LEN_W-1:0];
        default: ;
      endcase
    end
  end

  xcfp_useq u_useq (
    .clk   (clk),
    .rst_n (rst_n),
    .flags (flags),
    .cw    (cw)
  );

  xcfp_dpath #(
    .PAYLOAD_DEPTH (PAYLOAD_DEPTH)
  ) u_dpath (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg          (cfg_r),
    .cw           (cw),
    .flags        (flags),
    .in_tvalid    (in_tvalid),
    .in_tready    (in_tready),
    .rx_byte      (in_tdata),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .payload_byte (payload_byte),
    .sender       (sender),
    .destination  (destination),
    .status       (status),
    .has_payload  (has_payload),
    .last         (last)
  );

  assign out_tdata = {destination, sender, payload_byte};
  assign out_tuser = {has_payload, status};
  assign out_tlast = last;

  a_no_take_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> (!out_tvalid || out_tready))
    else $error("input taken while result register blocked");

  a_single_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tuser[2]) |-> (out_tlast && out_tdata[7:0] == 8'd0))
    else $error("non-payload result not marked last or carries data");

  a_payload_is_good: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser[2]) |-> (out_tuser[1:0] == xcfp_pkg::ST_GOOD))
    else $error("payload result with bad status");

  a_burst_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser[2] && !out_tlast) |-> !in_tready)
    else $error("input taken during payload burst");

endmodule
